// ===== sv/bpa_pkg.sv =====
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int FRAMES_DEF = 4096;
  localparam int TOP_ORDER_DEF = 3;
  localparam int ADDR_W = 48;
  localparam int FRAME_SHIFT = 12;
  localparam int TAG_W = 4;
  localparam int PDATA_W = 64;
  localparam int PADDR_W = 4;

  localparam logic [TAG_W-1:0] TAG_ALLOC = 4'hA;
  localparam logic [TAG_W-1:0] TAG_BODY = 4'hB;
  localparam logic [TAG_W-1:0] TAG_VOID = 4'hC;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE = 2'd1;
  localparam logic [1:0] ACT_RESERVE = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_MEMORY = 3'd1;
  localparam logic [2:0] ST_BAD_ORDER = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOCATED = 3'd3;
  localparam logic [2:0] ST_RANGE_BUSY = 3'd4;

  localparam logic REG_REGION_BASE = 1'b0;
  localparam logic [ADDR_W-1:0] REGION_BASE_RESET = 48'h0000_1000_0000;

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        block_order;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] block_address;
  } rsp_t;

endpackage

// ===== sv/bpa_ram.sv =====
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/bpa_regs.sv =====
`timescale 1ns / 1ps
module bpa_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0]  paddr,
  input  logic [bpa_pkg::PDATA_W-1:0]  pwdata,
  output logic [bpa_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [bpa_pkg::ADDR_W-1:0]   region_base
);
  import bpa_pkg::*;

  logic sel_base;

  assign sel_base = (paddr[3] == REG_REGION_BASE);
  assign pready = 1'b1;
  assign prdata = sel_base ? PDATA_W'(region_base) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= REGION_BASE_RESET;
    end else if (psel && penable && pwrite && pready && sel_base) begin
      region_base <= pwdata[ADDR_W-1:0];
    end
  end

endmodule

// ===== sv/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake                      Word
// req      in         req_valid / req_ready          action, block_order, address
// rsp      out        rsp_valid / rsp_ready          status, block_address
// apb      in         psel, penable, pwrite, pready  region_base at offset 0
// After reset a clearing pass writes every frame entry, one a cycle.
// From acceptance to its result word, a request scans frames or probes orders, marks frames,
// and splits or merges blocks as needed, all through the single port of each table.
// Only one request is worked on at a time; req_ready is high only when the sequencer is idle.
// A finished result waits in the output register while the next request is taken.
module buddy_page_allocator #(
  parameter int FRAMES = bpa_pkg::FRAMES_DEF,
  parameter int TOP_ORDER = bpa_pkg::TOP_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  bpa_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output bpa_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0] paddr,
  input  logic [bpa_pkg::PDATA_W-1:0] pwdata,
  output logic [bpa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import bpa_pkg::*;

  localparam int FW = $clog2(FRAMES);
  localparam int LW = $clog2(FRAMES + 1);
  localparam int CW = TOP_ORDER + 1;
  localparam int LVW = (TOP_ORDER < 1) ? 1 : $clog2(TOP_ORDER + 1);
  localparam int TOP_SIZE = 1 << TOP_ORDER;
  localparam int USED = (FRAMES / TOP_SIZE) * TOP_SIZE;
  localparam int WW = LW + 8;
  localparam logic [LW-1:0] NIL = LW'(FRAMES);

  typedef enum logic [18:0] {
    S_CLEAR    = 19'h00001,
    S_IDLE     = 19'h00002,
    S_DECODE   = 19'h00004,
    S_FIND     = 19'h00008,
    S_SCAN_RD  = 19'h00010,
    S_SCAN_CHK = 19'h00020,
    S_CAND_RD  = 19'h00040,
    S_CAND_CHK = 19'h00080,
    S_UNL_RD   = 19'h00100,
    S_UNL_WR   = 19'h00200,
    S_SPLIT    = 19'h00400,
    S_PUSH1    = 19'h00800,
    S_PUSH2    = 19'h01000,
    S_MARK     = 19'h02000,
    S_BUD_RD   = 19'h04000,
    S_BUD_CHK  = 19'h08000,
    S_MERGE    = 19'h10000,
    S_FIN      = 19'h20000,
    S_DONE     = 19'h40000
  } state_t;

  state_t state;
  logic [FW-1:0] clr;
  req_t req_q;
  logic [FW-1:0] idx;
  logic [FW-1:0] hblk;
  logic [FW-1:0] node;
  logic [LVW-1:0] lvl;
  logic [CW-1:0] cnt;
  logic [LW-1:0] head [TOP_ORDER+1];
  logic [2:0] st;
  logic [ADDR_W-1:0] res_addr;
  logic [ADDR_W-1:0] region_base;

  logic tag_we, nxt_we, prv_we;
  logic [FW-1:0] tag_addr, nxt_addr, prv_addr;
  logic [TAG_W-1:0] tag_wd, tag_rd;
  logic [LW-1:0] nxt_wd, nxt_rd, prv_wd, prv_rd;

  logic [ADDR_W-1:0] diff;
  logic [ADDR_W-FRAME_SHIFT-1:0] aligned;
  logic in_range;
  logic [CW-1:0] sz;
  logic found;
  logic [LVW-1:0] fj;
  logic [LVW-1:0] jn;
  logic [FW-1:0] up, other, newh, cand, bud, hmin;
  logic [WW-1:0] bud_w;
  logic bud_ok;
  logic [LW-1:0] head_rd;
  logic [TAG_W-1:0] init_tag;
  logic [LW-1:0] init_next, init_prev;
  logic [31:0] clr32;
  logic scan_bad;
  logic at_top;
  logic [ADDR_W-1:0] frame_addr;

  bpa_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .region_base(region_base)
  );

  bpa_ram #(.WIDTH(TAG_W), .DEPTH(FRAMES)) u_tag (
    .clk(clk), .we(tag_we), .addr(tag_addr), .wdata(tag_wd), .rdata(tag_rd)
  );

  bpa_ram #(.WIDTH(LW), .DEPTH(FRAMES)) u_next (
    .clk(clk), .we(nxt_we), .addr(nxt_addr), .wdata(nxt_wd), .rdata(nxt_rd)
  );

  bpa_ram #(.WIDTH(LW), .DEPTH(FRAMES)) u_prev (
    .clk(clk), .we(prv_we), .addr(prv_addr), .wdata(prv_wd), .rdata(prv_rd)
  );

  assign req_ready = (state == S_IDLE);
  assign head_rd = head[lvl];
  assign at_top = (lvl == LVW'(TOP_ORDER));

  always_comb begin
    diff = req_q.address - region_base;
    sz = CW'(1) << req_q.block_order;
    aligned = diff[ADDR_W-1:FRAME_SHIFT] & ~((ADDR_W-FRAME_SHIFT)'(sz) - 1'b1);
    in_range = ({1'b0, aligned} + (ADDR_W-FRAME_SHIFT+1)'(sz))
               <= (ADDR_W-FRAME_SHIFT+1)'(FRAMES);
  end

  always_comb begin
    found = 1'b0;
    fj = '0;
    for (int j = 0; j <= TOP_ORDER; j++) begin
      if (!found && (j >= int'(req_q.block_order)) && (head[j] != NIL)) begin
        found = 1'b1;
        fj = LVW'(j);
      end
    end
  end

  always_comb begin
    jn = lvl - 1'b1;
    up = hblk + (FW'(1) << jn);
    if (req_q.action == ACT_RESERVE && idx >= up) begin
      other = hblk;
      newh = up;
    end else begin
      other = up;
      newh = hblk;
    end
    cand = idx & ~((FW'(1) << lvl) - 1'b1);
    bud_w = WW'(hblk) ^ (WW'(1) << lvl);
    bud_ok = bud_w < WW'(FRAMES);
    bud = bud_w[FW-1:0];
    hmin = (node < hblk) ? node : hblk;
    frame_addr = region_base + (ADDR_W'(idx) << FRAME_SHIFT);
  end

  always_comb begin
    clr32 = 32'(clr);
    if (clr32 < USED) begin
      init_tag = (clr32 % TOP_SIZE == 0) ? TAG_W'(TOP_ORDER) : TAG_BODY;
    end else begin
      init_tag = TAG_VOID;
    end
    init_next = (clr32 + TOP_SIZE < USED) ? LW'(clr32 + TOP_SIZE) : NIL;
    init_prev = (clr32 >= TOP_SIZE) ? LW'(clr32 - TOP_SIZE) : NIL;
    if (req_q.action == ACT_FREE) begin
      scan_bad = (tag_rd != TAG_ALLOC);
    end else begin
      scan_bad = (tag_rd == TAG_ALLOC) || (tag_rd == TAG_VOID);
    end
  end

  always_comb begin
    tag_we = 1'b0;
    tag_addr = idx + FW'(cnt);
    tag_wd = TAG_BODY;
    nxt_we = 1'b0;
    nxt_addr = node;
    nxt_wd = NIL;
    prv_we = 1'b0;
    prv_addr = node;
    prv_wd = NIL;
    unique case (state)
      S_CLEAR: begin
        tag_we = 1'b1;
        tag_addr = clr;
        tag_wd = init_tag;
        nxt_we = 1'b1;
        nxt_addr = clr;
        nxt_wd = init_next;
        prv_we = 1'b1;
        prv_addr = clr;
        prv_wd = init_prev;
      end
      S_CAND_RD, S_CAND_CHK: begin
        tag_addr = cand;
      end
      S_UNL_WR: begin
        if (prv_rd != NIL) begin
          nxt_we = 1'b1;
          nxt_addr = prv_rd[FW-1:0];
          nxt_wd = nxt_rd;
        end
        if (nxt_rd != NIL) begin
          prv_we = 1'b1;
          prv_addr = nxt_rd[FW-1:0];
          prv_wd = prv_rd;
        end
      end
      S_SPLIT: begin
        if (3'(lvl) > req_q.block_order) begin
          tag_we = 1'b1;
          tag_addr = other;
          tag_wd = TAG_W'(jn);
        end
      end
      S_PUSH1: begin
        nxt_we = 1'b1;
        nxt_wd = head_rd;
        prv_we = 1'b1;
        prv_wd = NIL;
      end
      S_PUSH2: begin
        if (head_rd != NIL) begin
          prv_we = 1'b1;
          prv_addr = head_rd[FW-1:0];
          prv_wd = LW'(node);
        end
      end
      S_MARK: begin
        tag_we = 1'b1;
        tag_wd = (req_q.action == ACT_FREE) ? TAG_BODY : TAG_ALLOC;
      end
      S_BUD_RD, S_BUD_CHK: begin
        tag_addr = bud;
      end
      S_MERGE: begin
        tag_we = 1'b1;
        tag_addr = hmin + (FW'(1) << lvl);
        tag_wd = TAG_BODY;
      end
      S_FIN: begin
        tag_we = 1'b1;
        tag_addr = hblk;
        tag_wd = TAG_W'(lvl);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      rsp_valid <= 1'b0;
      for (int j = 0; j <= TOP_ORDER; j++) begin
        head[j] <= (j == TOP_ORDER && USED > 0) ? '0 : NIL;
      end
    end else begin
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == FRAMES - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          cnt <= '0;
          lvl <= LVW'(req_q.block_order);
          idx <= in_range ? aligned[FW-1:0] : '0;
          res_addr <= '0;
          st <= ST_OK;
          if (req_q.action == ACT_NONE) begin
            state <= S_DONE;
          end else if (req_q.block_order > 3'(TOP_ORDER)) begin
            st <= ST_BAD_ORDER;
            state <= S_DONE;
          end else if (req_q.action == ACT_ALLOC) begin
            state <= S_FIND;
          end else if (!in_range) begin
            st <= (req_q.action == ACT_FREE) ? ST_NOT_ALLOCATED : ST_RANGE_BUSY;
            state <= S_DONE;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_FIND: begin
          if (!found) begin
            st <= ST_NO_MEMORY;
            state <= S_DONE;
          end else begin
            lvl <= fj;
            node <= head[fj][FW-1:0];
            hblk <= head[fj][FW-1:0];
            idx <= head[fj][FW-1:0];
            state <= S_UNL_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (scan_bad) begin
            st <= (req_q.action == ACT_FREE) ? ST_NOT_ALLOCATED : ST_RANGE_BUSY;
            state <= S_DONE;
          end else if (cnt + 1'b1 == sz) begin
            cnt <= '0;
            state <= (req_q.action == ACT_FREE) ? S_MARK : S_CAND_RD;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_CAND_RD: begin
          state <= S_CAND_CHK;
        end
        S_CAND_CHK: begin
          if (tag_rd == TAG_W'(lvl)) begin
            hblk <= cand;
            node <= cand;
            state <= S_UNL_RD;
          end else if (at_top) begin
            st <= ST_RANGE_BUSY;
            state <= S_DONE;
          end else begin
            lvl <= lvl + 1'b1;
            state <= S_CAND_RD;
          end
        end
        S_UNL_RD: begin
          state <= S_UNL_WR;
        end
        S_UNL_WR: begin
          if (prv_rd == NIL) begin
            head[lvl] <= nxt_rd;
          end
          state <= (req_q.action == ACT_FREE) ? S_MERGE : S_SPLIT;
        end
        S_SPLIT: begin
          if (3'(lvl) > req_q.block_order) begin
            lvl <= jn;
            hblk <= newh;
            node <= other;
            state <= S_PUSH1;
          end else begin
            state <= S_MARK;
          end
        end
        S_PUSH1: begin
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          head[lvl] <= LW'(node);
          state <= (req_q.action == ACT_FREE) ? S_DONE : S_SPLIT;
        end
        S_MARK: begin
          if (cnt + 1'b1 == sz) begin
            cnt <= '0;
            if (req_q.action == ACT_FREE) begin
              hblk <= idx;
              lvl <= LVW'(req_q.block_order);
              state <= S_BUD_RD;
            end else begin
              res_addr <= frame_addr;
              state <= S_DONE;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_BUD_RD: begin
          state <= (at_top || !bud_ok) ? S_FIN : S_BUD_CHK;
        end
        S_BUD_CHK: begin
          if (tag_rd != TAG_W'(lvl)) begin
            state <= S_FIN;
          end else begin
            node <= bud;
            state <= S_UNL_RD;
          end
        end
        S_MERGE: begin
          hblk <= hmin;
          lvl <= lvl + 1'b1;
          state <= S_BUD_RD;
        end
        S_FIN: begin
          node <= hblk;
          state <= S_PUSH1;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.status <= st;
            rsp.block_address <= res_addr;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_DECODE))
    else $error("accepted request did not enter decode");

  a_mark_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (cnt < sz))
    else $error("mark counter ran past the block size");

  a_tag_range: assert property (@(posedge clk) disable iff (rst)
    tag_we |-> (32'(tag_addr) < FRAMES))
    else $error("tag write outside the frame range");

  a_push_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH2) |=> (head[$past(lvl)] == LW'($past(node))))
    else $error("list head not updated by push");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && !rsp_valid) |=> (rsp_valid && (state == S_IDLE)))
    else $error("result not loaded from done state");
`endif

endmodule

// ===== verif/buddy_page_allocator_test.sv =====
`timescale 1ns / 1ps
module buddy_page_allocator_test;
  import bpa_pkg::*;

  localparam int NFR = FRAMES_DEF;
  localparam int TOPO = TOP_ORDER_DEF;
  localparam int NIL = NFR;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 500;
  localparam int RELEASE_COUNT = 60;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  buddy_page_allocator u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct {
    int frame;
    int ord;
  } blk_t;

  logic [ADDR_W-1:0] base_reg;
  logic [TAG_W-1:0] tag_mem[NFR];
  int nxt_link[NFR];
  int prv_link[NFR];
  int head_of[TOPO+1];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  blk_t live_blocks[$];

  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int status_seen[8] = '{default: 0};
  int idle_cycles = 0;
  logic req_fire;
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  int mode_left = 0;
  bit calm_mode;
  int hold_left = 0;
  int hold_requests = 0;
  int hold_served = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic void list_push(int o, int n);
    int h;
    h = head_of[o];
    prv_link[n] = NIL;
    nxt_link[n] = h;
    if (h < NIL) prv_link[h] = n;
    head_of[o] = n;
  endfunction

  function automatic void list_unlink(int o, int n);
    int p;
    int x;
    p = prv_link[n];
    x = nxt_link[n];
    if (p < NIL) nxt_link[p] = x;
    else head_of[o] = x;
    if (x < NIL) prv_link[x] = p;
    nxt_link[n] = NIL;
    prv_link[n] = NIL;
  endfunction

  function automatic void reset_allocator_model();
    int last;
    base_reg = REGION_BASE_RESET;
    last = NIL;
    for (int j = 0; j <= TOPO; j++) head_of[j] = NIL;
    for (int i = 0; i < NFR; i++) begin
      nxt_link[i] = NIL;
      prv_link[i] = NIL;
      tag_mem[i] = TAG_VOID;
    end
    for (int i = 0; i + (1 << TOPO) <= NFR; i += (1 << TOPO)) begin
      for (int k = 0; k < (1 << TOPO); k++) tag_mem[i+k] = TAG_BODY;
      tag_mem[i] = TAG_W'(TOPO);
      prv_link[i] = last;
      if (last < NIL) nxt_link[last] = i;
      else head_of[TOPO] = i;
      last = i;
    end
  endfunction

  function automatic logic [ADDR_W-1:0] frame_addr(int idx);
    return base_reg + (ADDR_W'(idx) << FRAME_SHIFT);
  endfunction

  function automatic rsp_t predict_allocation(req_t r);
    rsp_t o;
    int ord;
    int sz;
    int idx;
    int i;
    int h;
    int j;
    int bud;
    int cand;
    int other;
    logic [ADDR_W-1:0] off;
    longint unsigned idx64;
    bit in_range;
    o = '0;
    ord = int'(r.block_order);
    if (r.action == ACT_NONE) return o;
    if (ord > TOPO) begin
      o.status = ST_BAD_ORDER;
      return o;
    end
    sz = 1 << ord;
    off = r.address - base_reg;
    idx64 = longint'(off >> FRAME_SHIFT);
    idx64 = idx64 & ~longint'(sz - 1);
    in_range = (idx64 + sz) <= NFR;
    idx = in_range ? int'(idx64) : 0;
    if (r.action == ACT_ALLOC) begin
      j = ord;
      while (j <= TOPO && head_of[j] >= NIL) j++;
      if (j > TOPO) begin
        o.status = ST_NO_MEMORY;
      end else begin
        h = head_of[j];
        list_unlink(j, h);
        while (j > ord) begin
          j--;
          tag_mem[h + (1 << j)] = TAG_W'(j);
          list_push(j, h + (1 << j));
        end
        for (int k = 0; k < sz; k++) tag_mem[h+k] = TAG_ALLOC;
        o.block_address = frame_addr(h);
      end
    end else if (r.action == ACT_FREE) begin
      i = 0;
      if (in_range) while (i < sz && tag_mem[idx+i] == TAG_ALLOC) i++;
      if (!in_range || i < sz) begin
        o.status = ST_NOT_ALLOCATED;
      end else begin
        for (int k = 0; k < sz; k++) tag_mem[idx+k] = TAG_BODY;
        h = idx;
        j = ord;
        while (j < TOPO) begin
          bud = h ^ (1 << j);
          if (bud >= NIL || tag_mem[bud] != j) break;
          list_unlink(j, bud);
          if (bud < h) h = bud;
          tag_mem[h + (1 << j)] = TAG_BODY;
          j++;
        end
        tag_mem[h] = TAG_W'(j);
        list_push(j, h);
      end
    end else begin
      h = NIL;
      if (in_range) begin
        i = 0;
        while (i < sz && tag_mem[idx+i] != TAG_ALLOC && tag_mem[idx+i] != TAG_VOID) i++;
        if (i == sz) begin
          for (j = ord; j <= TOPO; j++) begin
            cand = idx & ~((1 << j) - 1);
            if (tag_mem[cand] == j) begin
              h = cand;
              break;
            end
          end
        end
      end
      if (h >= NIL) begin
        o.status = ST_RANGE_BUSY;
      end else begin
        list_unlink(j, h);
        while (j > ord) begin
          j--;
          if (idx >= h + (1 << j)) begin
            other = h;
            h = h + (1 << j);
          end else begin
            other = h + (1 << j);
          end
          tag_mem[other] = TAG_W'(j);
          list_push(j, other);
        end
        for (int k = 0; k < sz; k++) tag_mem[idx+k] = TAG_ALLOC;
        o.block_address = frame_addr(idx);
      end
    end
    return o;
  endfunction

  task automatic queue_request(logic [1:0] act, int ord, logic [ADDR_W-1:0] addr);
    req_t r;
    rsp_t e;
    blk_t b;
    r.action = act;
    r.block_order = ord[2:0];
    r.address = addr;
    e = predict_allocation(r);
    if (e.status == ST_OK && (act == ACT_ALLOC || act == ACT_RESERVE)) begin
      b.frame = int'((e.block_address - base_reg) >> FRAME_SHIFT);
      b.ord = ord;
      live_blocks.push_back(b);
    end
    pending_reqs.push_back(r);
    expected_rsps.push_back(e);
  endtask

  task automatic free_live(int pick);
    blk_t b;
    b = live_blocks[pick];
    live_blocks.delete(pick);
    queue_request(ACT_FREE, b.ord, frame_addr(b.frame) | ADDR_W'($urandom_range(0, 4095)));
  endtask

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    errors++;
    $display("mismatch %s: got %h, expected %h", what, got, want);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_region_base(logic [ADDR_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[ADDR_W-1:0] !== value) report_mismatch("region_base readback", prdata[ADDR_W-1:0], value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    base_reg = value;
  endtask

  task automatic random_phase(int count);
    int pick;
    int ord;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      ord = ($urandom_range(0, 19) == 0) ? int'($urandom_range(4, 7))
                                          : int'($urandom_range(0, TOPO));
      if (pick < 40) begin
        queue_request(ACT_ALLOC, ord, ADDR_W'({$urandom, $urandom}));
      end else if (pick < 70 && live_blocks.size() != 0) begin
        free_live($urandom_range(0, live_blocks.size() - 1));
      end else if (pick < 85) begin
        queue_request(ACT_RESERVE, ord,
                      frame_addr($urandom_range(0, NFR - 1)) | ADDR_W'($urandom_range(0, 4095)));
      end else if (pick < 90) begin
        queue_request(ACT_FREE, ord, frame_addr($urandom_range(0, NFR - 1)));
      end else begin
        queue_request(2'($urandom_range(0, 3)), int'($urandom_range(0, 7)),
                      ADDR_W'({$urandom, $urandom}));
      end
    end
  endtask

  always @(posedge clk) begin
    req_fire <= req_valid && req_ready;
    if (rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected word", rsp.block_address, '0);
      end else begin
        if (rsp.status !== expected_rsps[0].status)
          report_mismatch("status", ADDR_W'(rsp.status), ADDR_W'(expected_rsps[0].status));
        if (rsp.block_address !== expected_rsps[0].block_address)
          report_mismatch("block_address", rsp.block_address, expected_rsps[0].block_address);
        status_seen[expected_rsps[0].status]++;
        expected_rsps.delete(0);
      end
      words_checked++;
    end
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req <= pending_reqs[0];
        pending_reqs.delete(0);
        req_valid <= 1'b1;
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (mode_left <= 0) begin
      mode_left = $urandom_range(50, 400);
      calm_mode = $urandom_range(0, 2) == 0;
    end
    mode_left--;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      if (!calm_mode && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 70);
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    reset_allocator_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    queue_request(ACT_ALLOC, 0, '0);
    queue_request(ACT_ALLOC, 1, '1);
    queue_request(ACT_ALLOC, 2, '0);
    queue_request(ACT_ALLOC, TOPO, '0);
    queue_request(ACT_ALLOC, 4, '0);
    queue_request(ACT_FREE, 7, frame_addr(0));
    queue_request(ACT_RESERVE, 5, frame_addr(8));
    queue_request(ACT_NONE, 2, '1);
    queue_request(ACT_FREE, 0, frame_addr(0) | 48'hFFF);
    live_blocks.delete(0);
    queue_request(ACT_FREE, 0, frame_addr(0));
    queue_request(ACT_FREE, 0, base_reg - 48'h1000);
    queue_request(ACT_RESERVE, TOPO, frame_addr(NFR - 8));
    queue_request(ACT_RESERVE, TOPO, frame_addr(NFR - 8));
    queue_request(ACT_RESERVE, 0, frame_addr(NFR - 1));
    queue_request(ACT_RESERVE, 1, frame_addr(NFR) | 48'h800);
    queue_request(ACT_FREE, TOPO, frame_addr(NFR - 5));
    void'(live_blocks.pop_back());
    queue_request(ACT_RESERVE, 0, frame_addr(NFR - 1));
    queue_request(ACT_FREE, 0, frame_addr(NFR - 1));
    void'(live_blocks.pop_back());
    queue_request(ACT_RESERVE, 2, frame_addr(1));
    queue_request(ACT_FREE, 2, frame_addr(5));
    while (live_blocks.size() != 0) free_live(0);
    wait_idle();

    write_region_base('0);
    for (int n = 0; n < NFR / 8 + 2; n++) queue_request(ACT_ALLOC, TOPO, '0);
    queue_request(ACT_ALLOC, 0, '0);
    queue_request(ACT_RESERVE, 0, frame_addr(17));
    for (int n = 0; n < RELEASE_COUNT && live_blocks.size() != 0; n++)
      free_live($urandom_range(0, live_blocks.size() - 1));
    queue_request(ACT_ALLOC, 1, '0);
    wait_idle();

    write_region_base(48'hFFFF_FFFF_F000);
    random_phase(50);
    wait_idle();

    write_region_base(ADDR_W'({$urandom, $urandom}));
    hold_requests++;
    random_phase(60);
    wait_idle();

    $display("sent %0d request words, checked %0d response words", words_sent, words_checked);
    $display("statuses: ok %0d, no memory %0d, bad order %0d, not allocated %0d, busy %0d",
             status_seen[ST_OK], status_seen[ST_NO_MEMORY], status_seen[ST_BAD_ORDER],
             status_seen[ST_NOT_ALLOCATED], status_seen[ST_RANGE_BUSY]);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
